// ----- rtl/bilinear_image_downscaler_assert.svh -----
// Assertion macros used by the downscaler checker.
`ifndef BILINEAR_IMAGE_DOWNSCALER_ASSERT_SVH
`define BILINEAR_IMAGE_DOWNSCALER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define BIDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Antecedent implies consequent a fixed number of cycles later.
`define BIDS_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed: delayed implication");

`endif

// ----- rtl/bids_pkg.sv -----
// Shared types and constants of the bilinear image downscaler.
package bids_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int COORD_W    = 12;
   localparam int PIXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int SIZE_W     = 13;
   localparam int SRC_SIZE_W = 9;
   localparam int STEP_W     = 24;
   localparam int OFFSET_W   = 13;
   localparam int MAP_W      = 38;
   localparam int POS_SHIFT  = 17;
   localparam int RSP_LATENCY = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_STEP       = 3'd2,
      CSR_OFFSET_X   = 3'd3,
      CSR_OPAQUE     = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

endpackage

// ----- rtl/bids_ram.sv -----
// Generic single-port RAM with registered read data.
module bids_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ----- rtl/bilinear_image_downscaler.sv -----
// Top level of the bilinear RGBA8888 image downscaler.
//
// Usage: a transaction is taken on the request channel when start is high and
// busy is low. A load (req_cmd = 0) writes req_pixel into the pixel store at
// (req_col, req_row) when that lies in the store, and gives no response. A sample
// (req_cmd = 1) maps the output point to the source image, reads the four
// neighbours one after another from the single-port pixel memory and blends them.
// The response appears on the rsp_ ports for one cycle, flagged by rsp_valid.
// Throughput: a load every cycle while busy is low; a new sample is taken only
// once the four reads of the one memory port are done. busy is high during
// those reads, and a new transaction is taken while earlier blends finish.
// Registers are written over the csr_ channel (always ready); the user must
// write them only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and drops all work in flight; the
// pixel store is not cleared and must be loaded before it is sampled.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module bilinear_image_downscaler
   import bids_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [COORD_W-1:0]    req_row,
   input  logic [PIXEL_W-1:0]    req_pixel,
   output logic                  rsp_valid,
   output logic [CHAN_W-1:0]     rsp_red,
   output logic [CHAN_W-1:0]     rsp_green,
   output logic [CHAN_W-1:0]     rsp_blue,
   output logic [CHAN_W-1:0]     rsp_alpha,
   output logic                  rsp_inside_res,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = MAP_W - POS_SHIFT;
   localparam int TW    = FRAC_BITS + CHAN_W;
   localparam int BW    = 2 * FRAC_BITS + CHAN_W;

   // Configuration registers.
   logic [SRC_SIZE_W-1:0] src_w_ff, src_h_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [OFFSET_W-1:0]   off_ff;
   logic                  opq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SRC_SIZE_W'(256);
         src_h_ff <= SRC_SIZE_W'(256);
         step_ff  <= STEP_W'(65536);
         off_ff   <= '0;
         opq_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_w_ff <= csr_data[SRC_SIZE_W-1:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_data[SRC_SIZE_W-1:0];
            CSR_STEP:       step_ff  <= csr_data[STEP_W-1:0];
            CSR_OFFSET_X:   off_ff   <= csr_data[OFFSET_W-1:0];
            CSR_OPAQUE:     opq_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Saturated image size.
   logic [SIZE_W-1:0] w_lim, h_lim;

   always_comb begin
      if (src_w_ff == '0) begin
         w_lim = SIZE_W'(1);
      end else if (SIZE_W'(src_w_ff) > SIZE_W'(MAX_WIDTH)) begin
         w_lim = SIZE_W'(MAX_WIDTH);
      end else begin
         w_lim = SIZE_W'(src_w_ff);
      end
      if (src_h_ff == '0) begin
         h_lim = SIZE_W'(1);
      end else if (SIZE_W'(src_h_ff) > SIZE_W'(MAX_HEIGHT)) begin
         h_lim = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_lim = SIZE_W'(src_h_ff);
      end
   end

   // Request accept and coordinate mapping.
   logic accept, sample_acc, load_acc, load_ok;
   logic [MAP_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [OFFSET_W:0] xs;

   assign accept     = start && !busy;
   assign sample_acc = accept && (cmd_type'(req_cmd) == CMD_SAMPLE);
   assign load_acc   = accept && (cmd_type'(req_cmd) == CMD_LOAD);
   assign load_ok    = ({1'b0, req_col} < SIZE_W'(MAX_WIDTH)) &&
                       ({1'b0, req_row} < SIZE_W'(MAX_HEIGHT));

   assign xs    = {1'b0, req_col, 1'b0} + {1'b0, off_ff};
   assign nx_in = MAP_W'(xs) * MAP_W'(step_ff);
   assign ny_in = MAP_W'({req_row, 1'b0}) * MAP_W'(step_ff);

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
   end

   // Read sequencer: four neighbour reads, one per cycle.
   logic       active_ff;
   logic [1:0] phase_ff;

   assign busy = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= '0;
      end else if (sample_acc) begin
         active_ff <= 1'b1;
         phase_ff  <= '0;
      end else if (active_ff) begin
         phase_ff <= phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            active_ff <= 1'b0;
         end
      end
   end

   // Neighbour coordinates with clamping at the right and bottom edges.
   logic [IW-1:0]        x_int, y_int;
   logic                 x_edge, y_edge, in_image;
   logic [XW-1:0]        x_lo, x_hi, x_sel;
   logic [YW-1:0]        y_lo, y_hi, y_sel;
   logic [FRAC_BITS-1:0] fx, fy;

   assign x_int  = nx_ff[MAP_W-1:POS_SHIFT];
   assign y_int  = ny_ff[MAP_W-1:POS_SHIFT];
   assign x_edge = x_int >= IW'(w_lim - SIZE_W'(1));
   assign y_edge = y_int >= IW'(h_lim - SIZE_W'(1));
   assign in_image = (nx_ff <= MAP_W'({w_lim, {POS_SHIFT{1'b0}}})) &&
                     (ny_ff <= MAP_W'({h_lim, {POS_SHIFT{1'b0}}}));

   assign x_lo  = x_edge ? XW'(w_lim - SIZE_W'(1)) : x_int[XW-1:0];
   assign x_hi  = x_edge ? x_lo : x_lo + XW'(1);
   assign y_lo  = y_edge ? YW'(h_lim - SIZE_W'(1)) : y_int[YW-1:0];
   assign y_hi  = y_edge ? y_lo : y_lo + YW'(1);
   assign fx    = x_edge ? '0 : nx_ff[POS_SHIFT-1 -: FRAC_BITS];
   assign fy    = y_edge ? '0 : ny_ff[POS_SHIFT-1 -: FRAC_BITS];
   assign x_sel = phase_ff[0] ? x_hi : x_lo;
   assign y_sel = phase_ff[1] ? y_hi : y_lo;

   // Pixel store.
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [PIXEL_W-1:0] mem_rdata;

   assign mem_we   = load_acc && load_ok;
   assign mem_addr = active_ff ? AW'(y_sel) * AW'(MAX_WIDTH) + AW'(x_sel)
                               : AW'(req_row) * AW'(MAX_WIDTH) + AW'(req_col);

   bids_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_pixel),
      .rdata (mem_rdata)
   );

   // Read data capture and sample parameters.
   logic                 rd_valid_ff;
   logic [1:0]           rd_phase_ff;
   logic [PIXEL_W-1:0]   c00_ff, c10_ff, c01_ff;
   logic [FRAC_BITS-1:0] m_fx_ff, m_fy_ff;
   logic                 m_in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_phase_ff <= phase_ff;
      if (active_ff && phase_ff == 2'd0) begin
         m_fx_ff <= fx;
         m_fy_ff <= fy;
         m_in_ff <= in_image;
      end
      if (rd_valid_ff) begin
         case (rd_phase_ff)
            2'd0:    c00_ff <= mem_rdata;
            2'd1:    c10_ff <= mem_rdata;
            2'd2:    c01_ff <= mem_rdata;
            default: ;
         endcase
      end
   end

   // Blend, horizontal then vertical, with a register after each.
   logic                 s1_valid_ff, s1_in_ff, s1_opq_ff;
   logic [FRAC_BITS-1:0] s1_fy_ff;
   logic [TW-1:0]        top_ff [4];
   logic [TW-1:0]        bot_ff [4];
   logic [TW-1:0]        top_in [4];
   logic [TW-1:0]        bot_in [4];
   logic [FRAC_BITS:0]   wx0, wy0;
   logic [BW-1:0]        acc [4];
   logic                 last_read;

   assign last_read = rd_valid_ff && (rd_phase_ff == 2'd3);
   assign wx0 = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(m_fx_ff);
   assign wy0 = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(s1_fy_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         top_in[k] = TW'(c00_ff[k*CHAN_W +: CHAN_W]) * TW'(wx0) +
                     TW'(c10_ff[k*CHAN_W +: CHAN_W]) * TW'(m_fx_ff);
         bot_in[k] = TW'(c01_ff[k*CHAN_W +: CHAN_W]) * TW'(wx0) +
                     TW'(mem_rdata[k*CHAN_W +: CHAN_W]) * TW'(m_fx_ff);
         acc[k]    = BW'(top_ff[k]) * BW'(wy0) + BW'(bot_ff[k]) * BW'(s1_fy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= last_read;
      end
   end

   always_ff @(posedge clock) begin
      if (last_read) begin
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         s1_fy_ff  <= m_fy_ff;
         s1_in_ff  <= m_in_ff;
         s1_opq_ff <= opq_ff;
      end
   end

   // Response register.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_inside_res <= s1_in_ff;
         rsp_red        <= s1_in_ff ? acc[0][BW-1 -: CHAN_W] : '0;
         rsp_green      <= s1_in_ff ? acc[1][BW-1 -: CHAN_W] : '0;
         rsp_blue       <= s1_in_ff ? acc[2][BW-1 -: CHAN_W] : '0;
         if (s1_opq_ff) begin
            rsp_alpha <= '1;
         end else begin
            rsp_alpha <= s1_in_ff ? acc[3][BW-1 -: CHAN_W] : '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/bids_checker.sv -----
// Port-level checker for the bilinear image downscaler, bound to the top level.
`include "bilinear_image_downscaler_assert.svh"

module bids_checker
   import bids_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_cmd,
   input logic                  rsp_valid,
   input logic [CHAN_W-1:0]     rsp_red,
   input logic [CHAN_W-1:0]     rsp_green,
   input logic [CHAN_W-1:0]     rsp_blue,
   input logic                  rsp_inside_res
);

   logic sample_acc, load_acc;

   assign sample_acc = start && !busy && (cmd_type'(req_cmd) == CMD_SAMPLE);
   assign load_acc   = start && !busy && (cmd_type'(req_cmd) == CMD_LOAD);

   // Every accepted sample transaction produces a response on rsp_valid.
   `BIDS_ASSERT_DELAY(a_sample_rsp, clock, reset, sample_acc, 7, rsp_valid)
   // A load never produces a response.
   `BIDS_ASSERT_DELAY(a_load_silent, clock, reset, load_acc, 7, !rsp_valid)
   // The memory port is held for the neighbour reads after a sample.
   `BIDS_ASSERT_DELAY(a_sample_busy, clock, reset, sample_acc, 1, busy)
   // Points outside the image give zero color.
   `BIDS_ASSERT_IMPLY(a_outside_zero, clock, reset, rsp_valid && !rsp_inside_res, rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)

endmodule

bind bilinear_image_downscaler bids_checker u_bids_checker (.*);
